>>> rtl/tfhd_pkg.sv
// Shared types and constants for the frame header deframer.
// No dependencies; compiled first.
`default_nettype none

package tfhd_pkg;

    typedef logic [5:0] t_pos;

    localparam t_pos HEADER_BYTES  = 6'd47;
    localparam t_pos SESSION_BYTES = 6'd16;

    localparam t_pos POS_MAGIC_END   = 6'd3;
    localparam t_pos POS_APP_ID      = 6'd4;
    localparam t_pos POS_APP_ID_END  = 6'd5;
    localparam t_pos POS_VERSION     = 6'd6;
    localparam t_pos POS_VERSION_END = 6'd9;
    localparam t_pos POS_HDR_LEN     = 6'd10;
    localparam t_pos POS_TOTAL       = 6'd12;
    localparam t_pos POS_TOTAL_END   = 6'd15;
    localparam t_pos POS_UIN         = 6'd16;
    localparam t_pos POS_UIN_END     = 6'd19;
    localparam t_pos POS_SESSION     = 6'd20;
    localparam t_pos POS_SESSION_MID = POS_SESSION + (SESSION_BYTES >> 1);
    localparam t_pos POS_SESSION_END = POS_SESSION + SESSION_BYTES;
    localparam t_pos POS_COMMAND     = 6'd36;
    localparam t_pos POS_COMMAND_END = 6'd39;
    localparam t_pos POS_SEQUENCE    = 6'd40;
    localparam t_pos POS_SEQ_END     = 6'd43;
    localparam t_pos POS_ERROR       = 6'd44;
    localparam t_pos POS_LAST        = HEADER_BYTES - 6'd1;

    localparam logic [31:0] FAIL_LEN_MAGIC   = 32'd4;
    localparam logic [31:0] FAIL_LEN_APP_ID  = 32'd6;
    localparam logic [31:0] FAIL_LEN_VERSION = 32'd10;
    localparam logic [31:0] FAIL_LEN_TOTAL   = 32'd16;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_BODY   = 2'd1,
        KIND_FAIL   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        REG_MAGIC   = 2'd0,
        REG_APP_ID  = 2'd1,
        REG_VERSION = 2'd2
    } t_reg_idx;

    typedef enum logic {
        PH_HEADER = 1'b0,
        PH_BODY   = 1'b1
    } t_phase;

    typedef struct packed {
        logic [31:0] magic_word;
        logic [15:0] application_id;
        logic [15:0] protocol_version;
    } t_cfg;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] user_number;
        logic [63:0] session_high;
        logic [63:0] session_low;
        logic [31:0] command_type;
        logic [31:0] sequence_number;
        logic [7:0]  error_code;
        logic [31:0] frame_length;
        logic [7:0]  body_byte;
        logic        last;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/tfhd_if.sv
// Channel interfaces: input byte stream, result stream, register write port.
// Depends on tfhd_pkg.
`default_nettype none

interface tfhd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface tfhd_out_if;
    import tfhd_pkg::*;
    logic        valid;
    logic        ready;
    t_kind       kind;
    logic [31:0] user_number;
    logic [63:0] session_high;
    logic [63:0] session_low;
    logic [31:0] command_type;
    logic [31:0] sequence_number;
    logic [7:0]  error_code;
    logic [31:0] frame_length;
    logic [7:0]  body_byte;
    logic        last;

    modport source (output valid, output kind, output user_number, output session_high,
                    output session_low, output command_type, output sequence_number,
                    output error_code, output frame_length, output body_byte,
                    output last, input ready);
    modport sink   (input valid, input kind, input user_number, input session_high,
                    input session_low, input command_type, input sequence_number,
                    input error_code, input frame_length, input body_byte,
                    input last, output ready);
endinterface

interface tfhd_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/tfhd_parser.sv
// Header field capture, checks and body counting, one byte per accepted transfer.
// Depends on tfhd_pkg.
`default_nettype none

module tfhd_parser (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire logic [7:0]       i_data_byte,
    input  wire tfhd_pkg::t_cfg   i_cfg,
    output logic                  o_res_valid,
    output tfhd_pkg::t_result     o_res
);
    import tfhd_pkg::*;

    t_phase      r_phase, n_phase;
    t_pos        r_pos, n_pos;
    logic [31:0] r_shift, n_shift;
    logic [31:0] r_uin, n_uin;
    logic [63:0] r_sess_hi, n_sess_hi;
    logic [63:0] r_sess_lo, n_sess_lo;
    logic [31:0] r_cmd, n_cmd;
    logic [31:0] r_seq, n_seq;
    logic [7:0]  r_err, n_err;
    logic [31:0] r_total, n_total;
    logic [31:0] r_rem, n_rem;

    logic        in_body;
    logic        be_start;
    logic        fail;
    logic [31:0] fail_len;
    logic [31:0] rem_dec;
    logic [31:0] payload_cnt;

    assign in_body     = (r_phase == PH_BODY) && (r_rem != 32'd0);
    assign rem_dec     = r_rem - 32'd1;
    assign payload_cnt = r_total - {26'd0, HEADER_BYTES};
    assign be_start = (r_pos == POS_APP_ID) || (r_pos == POS_VERSION) ||
                      (r_pos == POS_HDR_LEN) || (r_pos == POS_TOTAL) ||
                      (r_pos == POS_UIN) || (r_pos == POS_COMMAND) ||
                      (r_pos == POS_SEQUENCE);

    // field datapath
    always_comb begin
        n_shift   = r_shift;
        n_sess_hi = r_sess_hi;
        n_sess_lo = r_sess_lo;
        n_err     = r_err;
        n_uin     = r_uin;
        n_cmd     = r_cmd;
        n_seq     = r_seq;
        n_total   = r_total;
        if (!in_body) begin
            if (r_pos <= POS_MAGIC_END) begin
                n_shift = {i_data_byte, (r_pos == 6'd0) ? 24'd0 : r_shift[31:8]};
            end else if (r_pos >= POS_SESSION && r_pos < POS_SESSION_MID) begin
                n_sess_hi = (r_pos == POS_SESSION) ? {56'd0, i_data_byte}
                                                   : {r_sess_hi[55:0], i_data_byte};
            end else if (r_pos >= POS_SESSION_MID && r_pos < POS_SESSION_END) begin
                n_sess_lo = (r_pos == POS_SESSION_MID) ? {56'd0, i_data_byte}
                                                       : {r_sess_lo[55:0], i_data_byte};
            end else if (r_pos < POS_ERROR) begin
                n_shift = be_start ? {24'd0, i_data_byte} : {r_shift[23:0], i_data_byte};
            end else if (r_pos == POS_ERROR) begin
                n_err = i_data_byte;
            end
            if (r_pos == POS_TOTAL_END)   n_total = n_shift;
            if (r_pos == POS_UIN_END)     n_uin   = n_shift;
            if (r_pos == POS_COMMAND_END) n_cmd   = n_shift;
            if (r_pos == POS_SEQ_END)     n_seq   = n_shift;
        end
    end

    // checks
    always_comb begin
        fail     = 1'b0;
        fail_len = 32'd0;
        if (!in_body) begin
            if (r_pos == POS_MAGIC_END && n_shift != i_cfg.magic_word) begin
                fail     = 1'b1;
                fail_len = FAIL_LEN_MAGIC;
            end else if (r_pos == POS_APP_ID_END &&
                         n_shift != {16'd0, i_cfg.application_id}) begin
                fail     = 1'b1;
                fail_len = FAIL_LEN_APP_ID;
            end else if (r_pos == POS_VERSION_END &&
                         n_shift != {16'd0, i_cfg.protocol_version}) begin
                fail     = 1'b1;
                fail_len = FAIL_LEN_VERSION;
            end else if (r_pos == POS_TOTAL_END && n_shift < {26'd0, HEADER_BYTES}) begin
                fail     = 1'b1;
                fail_len = FAIL_LEN_TOTAL;
            end
        end
    end

    // next state
    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_rem   = r_rem;
        if (in_body) begin
            n_rem = rem_dec;
            if (rem_dec == 32'd0) begin
                n_phase = PH_HEADER;
                n_pos   = 6'd0;
            end
        end else if (fail) begin
            n_phase = PH_HEADER;
            n_pos   = 6'd0;
        end else if (r_pos >= POS_LAST) begin
            n_rem   = payload_cnt;
            n_pos   = 6'd0;
            n_phase = (payload_cnt == 32'd0) ? PH_HEADER : PH_BODY;
        end else begin
            n_phase = PH_HEADER;
            n_pos   = r_pos + 6'd1;
        end
    end

    // result
    always_comb begin
        o_res       = '0;
        o_res.kind  = KIND_HEADER;
        o_res_valid = 1'b0;
        if (in_body) begin
            o_res_valid        = i_accept;
            o_res.kind         = KIND_BODY;
            o_res.frame_length = r_total;
            o_res.body_byte    = i_data_byte;
            o_res.last         = (rem_dec == 32'd0);
        end else if (fail) begin
            o_res_valid        = i_accept;
            o_res.kind         = KIND_FAIL;
            o_res.frame_length = fail_len;
        end else if (r_pos >= POS_LAST) begin
            o_res_valid           = i_accept;
            o_res.kind            = KIND_HEADER;
            o_res.user_number     = r_uin;
            o_res.session_high    = r_sess_hi;
            o_res.session_low     = r_sess_lo;
            o_res.command_type    = r_cmd;
            o_res.sequence_number = r_seq;
            o_res.error_code      = n_err;
            o_res.frame_length    = r_total;
            o_res.last            = (payload_cnt == 32'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_pos   <= 6'd0;
            r_rem   <= 32'd0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_rem   <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_shift   <= n_shift;
            r_uin     <= n_uin;
            r_sess_hi <= n_sess_hi;
            r_sess_lo <= n_sess_lo;
            r_cmd     <= n_cmd;
            r_seq     <= n_seq;
            r_err     <= n_err;
            r_total   <= n_total;
        end
    end

`ifndef SYNTH
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos < HEADER_BYTES)
        else $error("header position out of range");

    a_body_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BODY) |-> (r_rem != 32'd0))
        else $error("body phase with nothing remaining");

    a_fail_resync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.kind == KIND_FAIL) |=> (r_pos == 6'd0 && r_phase == PH_HEADER))
        else $error("no resync after rejected header");
`endif

endmodule

`default_nettype wire

>>> rtl/tcp_frame_header_deframer.sv
// Top level of the frame header deframer: register port, parser, output skid stage.
// Depends on tfhd_pkg, tfhd_if and tfhd_parser.
//
// Usage:
//   i_in   : received stream, one byte per transfer (valid/ready).
//   o_out  : results - one header result per good 47-byte header, then one
//            result per body byte (last set on the final one, or on a header
//            with an empty body); a rejected header gives one fail result and
//            parsing restarts at the next byte.
//   i_cfg  : register writes (index 0 magic, 1 application id, 2 version),
//            always ready; write only while the stream is idle.
// A result is registered into the output register (or the skid register).
// Throughput: one byte per cycle while i_in.ready is high.
// A two-entry output (result register plus skid register) lets a byte be
// taken while one result waits; i_in.ready drops only once both are full,
// i.e. when a second result arrives while the receiver stalls the first.
// Reset (synchronous, active low) clears the config registers to zero, returns
// the parser to header byte 0 and empties the output stage.
`default_nettype none

module tcp_frame_header_deframer (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    tfhd_in_if.sink     i_in,
    tfhd_out_if.source  o_out,
    tfhd_cfg_if.sink    i_cfg
);
    import tfhd_pkg::*;

    t_cfg      r_cfg;
    t_result   r_out, r_skid;
    logic      r_out_valid, n_out_valid;
    logic      r_skid_valid, n_skid_valid;
    logic      load_out, load_skid, move_skid;
    logic      accept, take;
    logic      res_valid;
    t_result   res;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_skid_valid;
    assign accept      = i_in.valid && i_in.ready;
    assign take        = r_out_valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (t_reg_idx'(i_cfg.index))
                REG_MAGIC:   r_cfg.magic_word       <= i_cfg.data;
                REG_APP_ID:  r_cfg.application_id   <= i_cfg.data[15:0];
                REG_VERSION: r_cfg.protocol_version <= i_cfg.data[15:0];
                default: ;
            endcase
        end
    end

    tfhd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_in.data_byte),
        .i_cfg       (r_cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        load_out     = 1'b0;
        load_skid    = 1'b0;
        move_skid    = 1'b0;
        if (take) begin
            if (r_skid_valid) begin
                move_skid    = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = 1'b0;
            end
        end
        if (res_valid) begin
            if (!r_out_valid || take) begin
                load_out    = 1'b1;
                n_out_valid = 1'b1;
            end else begin
                load_skid    = 1'b1;
                n_skid_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= res;
        end else if (move_skid) begin
            r_out <= r_skid;
        end
        if (load_skid) begin
            r_skid <= res;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.kind            = r_out.kind;
    assign o_out.user_number     = r_out.user_number;
    assign o_out.session_high    = r_out.session_high;
    assign o_out.session_low     = r_out.session_low;
    assign o_out.command_type    = r_out.command_type;
    assign o_out.sequence_number = r_out.sequence_number;
    assign o_out.error_code      = r_out.error_code;
    assign o_out.frame_length    = r_out.frame_length;
    assign o_out.body_byte       = r_out.body_byte;
    assign o_out.last            = r_out.last;

`ifndef SYNTH
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with output register empty");

    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |=> r_out_valid)
        else $error("result transfer lost");

    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && r_out_valid && !o_out.ready) |=> r_skid_valid)
        else $error("stalled result not parked in skid stage");
`endif

endmodule

`default_nettype wire
